@@ hw/rtl/fcfl_pkg.sv @@
// Shared types and constants for the fixed chunk free list allocator.
package fcfl_pkg;

    localparam int INDEX_W  = 10;
    localparam int OFFSET_W = 26;
    localparam int CFG_W    = 17;
    localparam int STATUS_W = 2;

    localparam logic [CFG_W-1:0] CHUNK_BYTES_RESET = 17'd2048;
    localparam logic [CFG_W-1:0] CHUNK_BYTES_MIN   = 17'd1;
    localparam logic [CFG_W-1:0] CHUNK_BYTES_MAX   = 17'd65536;

    localparam logic [STATUS_W-1:0] STATUS_GRANTED   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FREED     = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic clear_step;
        logic load;
        logic exec;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
    } stat_t;

endpackage

@@ hw/rtl/fixed_chunk_free_list_allocator.sv @@
// Top level of the fixed chunk free list allocator.
// After reset the block runs a clearing pass that links every chunk to the next
// one in the link memory; busy stays high until it ends, and chunk size writes
// are taken throughout. A request (allocate or free) is taken when start is high
// and busy is low. Its operation and index are latched; in the execute state the
// head chunk's link, from the registered read of the link memory, and the offset
// multiply are used and the results registered; done then pulses with status,
// granted_index and byte_offset. The result is shown for that single cycle only
// and cannot be stalled; a new request may be issued in the same cycle done is
// high. Busy is high during the execute state, so requests never overlap.
module fixed_chunk_free_list_allocator #(
    parameter int CHUNKS = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               operation,
    input  logic [fcfl_pkg::INDEX_W-1:0]       chunk_index,
    output logic                               done,
    output logic [fcfl_pkg::STATUS_W-1:0]      status,
    output logic [fcfl_pkg::INDEX_W-1:0]       granted_index,
    output logic [fcfl_pkg::OFFSET_W-1:0]      byte_offset,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fcfl_pkg::CFG_W-1:0]         cfg_data
);

    fcfl_pkg::cmd_t  cmd;
    fcfl_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    fcfl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    fcfl_datapath #(
        .CHUNKS (CHUNKS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operation     (operation),
        .chunk_index   (chunk_index),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .done          (done),
        .status        (status),
        .granted_index (granted_index),
        .byte_offset   (byte_offset)
    );

    // every taken request must produce a done pulse
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("request did not produce a result two cycles later");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy && !done)
        else $error("busy or done wrong in the cycle after a request");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != fcfl_pkg::STATUS_GRANTED))
            |-> (granted_index == '0) && (byte_offset == '0))
        else $error("nonzero index or offset on a result that grants nothing");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == fcfl_pkg::STATUS_GRANTED) ||
                 (status == fcfl_pkg::STATUS_EXHAUSTED) ||
                 (status == fcfl_pkg::STATUS_FREED))
        else $error("undefined status code");

endmodule

@@ hw/rtl/fcfl_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module fcfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/fcfl_ctrl.sv @@
// Controller state machine: link clearing pass, idle, request execution.
module fcfl_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  fcfl_pkg::stat_t stat,
    output fcfl_pkg::cmd_t  cmd,
    output logic           busy
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd.clear_step = 1'b0;
        cmd.load       = 1'b0;
        cmd.exec       = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ hw/rtl/fcfl_datapath.sv @@
// Datapath: free list head, link memory, chunk size register, offset multiply, result registers.
module fcfl_datapath #(
    parameter int CHUNKS = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fcfl_pkg::cmd_t                      cmd,
    output fcfl_pkg::stat_t                     stat,
    input  logic                               operation,
    input  logic [fcfl_pkg::INDEX_W-1:0]       chunk_index,
    input  logic                               cfg_wr,
    input  logic [fcfl_pkg::CFG_W-1:0]         cfg_data,
    output logic                               done,
    output logic [fcfl_pkg::STATUS_W-1:0]      status,
    output logic [fcfl_pkg::INDEX_W-1:0]       granted_index,
    output logic [fcfl_pkg::OFFSET_W-1:0]      byte_offset
);

    localparam int IDX_W  = $clog2(CHUNKS);
    localparam int LINK_W = $clog2(CHUNKS + 1);
    localparam int PROD_W = IDX_W + fcfl_pkg::CFG_W;

    localparam logic [LINK_W-1:0] END_MARK = LINK_W'(CHUNKS);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(CHUNKS - 1);

    logic [LINK_W-1:0]              head_reg;
    logic [LINK_W-1:0]              head_next;
    logic [IDX_W-1:0]               clr_reg;
    logic                           op_reg;
    logic [fcfl_pkg::INDEX_W-1:0]   idx_reg;
    logic [fcfl_pkg::CFG_W-1:0]     chunk_bytes_reg;
    logic [fcfl_pkg::CFG_W-1:0]     chunk_bytes_next;
    logic                           done_reg;
    logic [fcfl_pkg::STATUS_W-1:0]  status_reg;
    logic [fcfl_pkg::STATUS_W-1:0]  status_next;
    logic [fcfl_pkg::INDEX_W-1:0]   granted_reg;
    logic [fcfl_pkg::INDEX_W-1:0]   granted_next;
    logic [fcfl_pkg::OFFSET_W-1:0]  offset_reg;
    logic [fcfl_pkg::OFFSET_W-1:0]  offset_next;

    logic                           ram_we;
    logic [IDX_W-1:0]               ram_waddr;
    logic [LINK_W-1:0]              ram_wdata;
    logic [LINK_W-1:0]              ram_rdata;
    logic [IDX_W-1:0]               taken;
    logic [PROD_W-1:0]              product;
    logic                           exhausted;
    logic                           idx_valid;

    assign taken     = head_reg[IDX_W-1:0];
    assign exhausted = (head_reg == END_MARK);
    assign idx_valid = (32'(idx_reg) < 32'(CHUNKS));
    assign product   = PROD_W'(taken) * PROD_W'(chunk_bytes_reg);

    assign stat.clear_last = cmd.clear_step && (clr_reg == LAST_IDX);

    // Clearing pass links entry i to i+1; a free of a valid index links the chunk to the old head
    always_comb
    begin
        if (cmd.clear_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = LINK_W'(clr_reg) + LINK_W'(1);
        end
        else
        begin
            ram_we    = cmd.exec && (op_reg == fcfl_pkg::OP_FREE) && idx_valid;
            ram_waddr = IDX_W'(idx_reg);
            ram_wdata = head_reg;
        end
    end

    fcfl_ram #(
        .WIDTH (LINK_W),
        .DEPTH (CHUNKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (taken),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        head_next    = head_reg;
        status_next  = fcfl_pkg::STATUS_FREED;
        granted_next = '0;
        offset_next  = '0;
        if (op_reg == fcfl_pkg::OP_ALLOC)
        begin
            if (exhausted)
            begin
                status_next = fcfl_pkg::STATUS_EXHAUSTED;
            end
            else
            begin
                // link of the head was read in the cycle the request was taken
                head_next    = ram_rdata;
                status_next  = fcfl_pkg::STATUS_GRANTED;
                granted_next = fcfl_pkg::INDEX_W'(taken);
                offset_next  = fcfl_pkg::OFFSET_W'(product);
            end
        end
        else if (idx_valid)
        begin
            head_next = LINK_W'(idx_reg);
        end
    end

    always_comb
    begin
        chunk_bytes_next = cfg_data;
        if (cfg_data == '0)
        begin
            chunk_bytes_next = fcfl_pkg::CHUNK_BYTES_MIN;
        end
        else if (cfg_data > fcfl_pkg::CHUNK_BYTES_MAX)
        begin
            chunk_bytes_next = fcfl_pkg::CHUNK_BYTES_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= '0;
            clr_reg         <= '0;
            chunk_bytes_reg <= fcfl_pkg::CHUNK_BYTES_RESET;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            if (cmd.exec)
            begin
                head_reg <= head_next;
            end
            if (cfg_wr)
            begin
                chunk_bytes_reg <= chunk_bytes_next;
            end
            done_reg <= cmd.exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            idx_reg <= chunk_index;
        end
        if (cmd.exec)
        begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
            offset_reg  <= offset_next;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign granted_index = granted_reg;
    assign byte_offset   = offset_reg;

endmodule
